@@ rtl/mbm_pkg.sv @@
// shared constants, types and codes of the multi-pattern byte matcher
package mbm_pkg;

  localparam int MAX_NODES    = 4096;
  localparam int NODE_W       = $clog2(MAX_NODES);
  localparam int NC_W         = NODE_W + 1;
  localparam int ALPHABET     = 256;
  localparam int SYM_W        = $clog2(ALPHABET);
  localparam int MAX_PATTERNS = 512;
  localparam int SEEN_AW      = $clog2(MAX_PATTERNS);
  localparam int PAT_W        = 10;
  localparam int CNT_W        = 10;
  localparam int NN_AW        = NODE_W + SYM_W;
  localparam int PS_W         = NODE_W + SYM_W;
  localparam int TERM_W       = PAT_W + 1;

  localparam logic [SYM_W-1:0]   SYM_LAST  = SYM_W'(ALPHABET - 1);
  localparam logic [SEEN_AW-1:0] SEEN_LAST = SEEN_AW'(MAX_PATTERNS - 1);
  localparam logic [NC_W-1:0]    NC_FULL   = NC_W'(MAX_NODES);
  localparam logic [PAT_W-1:0]   PC_FULL   = PAT_W'(MAX_PATTERNS);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PAT   = 2'd1,
    OP_BUILD = 2'd2,
    OP_TEXT  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SWEEP,
    ST_LK_ADDR, ST_LK_DATA, ST_LK_CHK,
    ST_P_STEP, ST_P_LAST,
    ST_B_ROOT, ST_B_ROOT_R, ST_B_POP, ST_B_Q, ST_B_F, ST_B_C, ST_B_V, ST_B_W,
    ST_T_MOVE, ST_T_CHK, ST_T_TERM, ST_T_SEEN, ST_T_END, ST_T_OUT
  } st_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [SYM_W-1:0] byte_value;
    logic             last;
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] match_count;
    logic             overflow;
  } res_t;

endpackage

@@ rtl/mbm_ram.sv @@
// generic single-write, single-read ram with registered read data
module mbm_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(2**AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mbm_engine.sv @@
// automaton sequencer: trie insert, breadth-first link build and text walk
module mbm_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  mbm_pkg::req_t req,
  output logic          ready,
  output mbm_pkg::res_t res,
  input  logic          res_ready
);
  import mbm_pkg::*;

  st_t state_r, state_nxt, ret_r, ret_nxt;
  op_t op_r, op_nxt;
  logic [SYM_W-1:0]  byte_r, byte_nxt, sym_r, sym_nxt, lk_sym_r, lk_sym_nxt;
  logic              last_r, last_nxt, lk_chk_r, lk_chk_nxt;
  logic [NODE_W-1:0] lk_node_r, lk_node_nxt, lk_d_r, lk_d_nxt, lk_res_r, lk_res_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt, now_r, now_nxt, f_r, f_nxt;
  logic [NODE_W-1:0] c_r, c_nxt, t_r, t_nxt;
  logic [NC_W-1:0]   nc_r, nc_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [PAT_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SEEN_AW-1:0] id_r, id_nxt, sw_r, sw_nxt;
  logic ovf_r, ovf_nxt, built_r, built_nxt, drop_r, drop_nxt;

  // memory ports
  logic nn_we, ps_we, fl_we, tm_we, q_we, sn_we;
  logic [NN_AW-1:0]   nn_waddr, nn_raddr;
  logic [NODE_W-1:0]  nn_wdata, nn_rdata;
  logic [NODE_W-1:0]  ps_waddr, ps_raddr, fl_waddr, fl_raddr, fl_wdata, fl_rdata;
  logic [PS_W-1:0]    ps_wdata, ps_rdata;
  logic [NODE_W-1:0]  tm_waddr, tm_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  logic [TERM_W-1:0]  tm_wdata, tm_rdata;
  logic [SEEN_AW-1:0] sn_waddr, sn_raddr;
  logic [0:0]         sn_wdata, sn_rdata;

  mbm_ram #(.DW(NODE_W), .AW(NN_AW)) u_next (.clk(clk), .we(nn_we), .waddr(nn_waddr),
    .wdata(nn_wdata), .raddr(nn_raddr), .rdata(nn_rdata));
  mbm_ram #(.DW(PS_W), .AW(NODE_W)) u_parent (.clk(clk), .we(ps_we), .waddr(ps_waddr),
    .wdata(ps_wdata), .raddr(ps_raddr), .rdata(ps_rdata));
  mbm_ram #(.DW(NODE_W), .AW(NODE_W)) u_fail (.clk(clk), .we(fl_we), .waddr(fl_waddr),
    .wdata(fl_wdata), .raddr(fl_raddr), .rdata(fl_rdata));
  mbm_ram #(.DW(TERM_W), .AW(NODE_W)) u_term (.clk(clk), .we(tm_we), .waddr(tm_waddr),
    .wdata(tm_wdata), .raddr(tm_raddr), .rdata(tm_rdata));
  mbm_ram #(.DW(NODE_W), .AW(NODE_W)) u_queue (.clk(clk), .we(q_we), .waddr(q_waddr),
    .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata));
  mbm_ram #(.DW(1), .AW(SEEN_AW)) u_seen (.clk(clk), .we(sn_we), .waddr(sn_waddr),
    .wdata(sn_wdata), .raddr(sn_raddr), .rdata(sn_rdata));

  assign ready           = (state_r == ST_IDLE);
  assign res.valid       = (state_r == ST_T_OUT);
  assign res.match_count = cnt_r;
  assign res.overflow    = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SWEEP;
      sw_r     <= '0;
      nc_r     <= NC_W'(1);
      pc_r     <= '0;
      cursor_r <= '0;
      ovf_r    <= 1'b0;
      built_r  <= 1'b0;
      drop_r   <= 1'b0;
      cnt_r    <= '0;
      ret_r    <= ST_IDLE;
    end else begin
      state_r  <= state_nxt;
      sw_r     <= sw_nxt;
      nc_r     <= nc_nxt;
      pc_r     <= pc_nxt;
      cursor_r <= cursor_nxt;
      ovf_r    <= ovf_nxt;
      built_r  <= built_nxt;
      drop_r   <= drop_nxt;
      cnt_r    <= cnt_nxt;
      ret_r    <= ret_nxt;
    end
    op_r      <= op_nxt;
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    sym_r     <= sym_nxt;
    lk_sym_r  <= lk_sym_nxt;
    lk_chk_r  <= lk_chk_nxt;
    lk_node_r <= lk_node_nxt;
    lk_d_r    <= lk_d_nxt;
    lk_res_r  <= lk_res_nxt;
    now_r     <= now_nxt;
    f_r       <= f_nxt;
    c_r       <= c_nxt;
    t_r       <= t_nxt;
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    id_r      <= id_nxt;
  end

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;
    op_nxt = op_r;         byte_nxt = byte_r;     last_nxt = last_r;
    sym_nxt = sym_r;       lk_sym_nxt = lk_sym_r; lk_chk_nxt = lk_chk_r;
    lk_node_nxt = lk_node_r; lk_d_nxt = lk_d_r;   lk_res_nxt = lk_res_r;
    cursor_nxt = cursor_r; now_nxt = now_r;       f_nxt = f_r;
    c_nxt = c_r;           t_nxt = t_r;
    nc_nxt = nc_r;         head_nxt = head_r;     tail_nxt = tail_r;
    pc_nxt = pc_r;         cnt_nxt = cnt_r;       id_nxt = id_r;  sw_nxt = sw_r;
    ovf_nxt = ovf_r;       built_nxt = built_r;   drop_nxt = drop_r;
    nn_we = 1'b0; nn_waddr = '0; nn_wdata = '0; nn_raddr = '0;
    ps_we = 1'b0; ps_waddr = '0; ps_wdata = '0; ps_raddr = '0;
    fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_raddr = '0;
    tm_we = 1'b0; tm_waddr = '0; tm_wdata = '0; tm_raddr = '0;
    q_we  = 1'b0; q_waddr  = '0; q_wdata  = '0; q_raddr  = '0;
    sn_we = 1'b0; sn_waddr = '0; sn_wdata = '0; sn_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (req.valid) begin
          op_nxt   = req.op;
          byte_nxt = req.byte_value;
          last_nxt = req.last;
          unique case (req.op)
            OP_CLEAR: begin
              nc_nxt = NC_W'(1);  pc_nxt = '0;  cursor_nxt = '0;
              ovf_nxt = 1'b0;  built_nxt = 1'b0;  drop_nxt = 1'b0;
              cnt_nxt = '0;  sw_nxt = '0;
              state_nxt = ST_SWEEP;
            end
            OP_PAT: begin
              if (built_r) begin
                state_nxt = ST_IDLE;
              end else if (drop_r) begin
                state_nxt = ST_P_LAST;
              end else begin
                lk_node_nxt = cursor_r;  lk_sym_nxt = req.byte_value;
                lk_chk_nxt = 1'b1;  ret_nxt = ST_P_STEP;
                state_nxt = ST_LK_ADDR;
              end
            end
            OP_BUILD: begin
              cursor_nxt = '0;
              drop_nxt   = 1'b0;
              if (!built_r) begin
                built_nxt = 1'b1;
                head_nxt  = '0;
                tail_nxt  = '0;
                sym_nxt   = '0;
                state_nxt = ST_B_ROOT;
              end
            end
            OP_TEXT: begin
              if (!built_r) begin
                state_nxt = ST_T_END;
              end else begin
                lk_node_nxt = cursor_r;  lk_sym_nxt = req.byte_value;
                lk_chk_nxt = (cursor_r == '0);  ret_nxt = ST_T_MOVE;
                state_nxt = ST_LK_ADDR;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SWEEP: begin
        sn_we = 1'b1;  sn_waddr = sw_r;  sn_wdata = 1'b0;
        sw_nxt = sw_r + 1'b1;
        if (sw_r == SEEN_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      // transition lookup: raw read, or checked against the child's parent record
      ST_LK_ADDR: begin
        nn_raddr  = {lk_node_r, lk_sym_r};
        state_nxt = ST_LK_DATA;
      end
      ST_LK_DATA: begin
        lk_d_nxt = nn_rdata;
        ps_raddr = nn_rdata;
        if (lk_chk_r) begin
          state_nxt = ST_LK_CHK;
        end else begin
          lk_res_nxt = nn_rdata;
          state_nxt  = ret_r;
        end
      end
      ST_LK_CHK: begin
        if ((lk_d_r != '0) && ({1'b0, lk_d_r} < nc_r) &&
            (ps_rdata == {lk_node_r, lk_sym_r})) begin
          lk_res_nxt = lk_d_r;
        end else begin
          lk_res_nxt = '0;
        end
        state_nxt = ret_r;
      end

      ST_P_STEP: begin
        if (lk_res_r == '0) begin
          if (nc_r < NC_FULL) begin
            nn_we = 1'b1;  nn_waddr = {cursor_r, byte_r};  nn_wdata = nc_r[NODE_W-1:0];
            ps_we = 1'b1;  ps_waddr = nc_r[NODE_W-1:0];    ps_wdata = {cursor_r, byte_r};
            tm_we = 1'b1;  tm_waddr = nc_r[NODE_W-1:0];    tm_wdata = '0;
            cursor_nxt = nc_r[NODE_W-1:0];
            nc_nxt     = nc_r + 1'b1;
          end else begin
            ovf_nxt  = 1'b1;
            drop_nxt = 1'b1;
          end
        end else begin
          cursor_nxt = lk_res_r;
        end
        state_nxt = ST_P_LAST;
      end
      ST_P_LAST: begin
        if (last_r) begin
          if (pc_r < PC_FULL) begin
            if (!drop_r) begin
              tm_we = 1'b1;  tm_waddr = cursor_r;  tm_wdata = {1'b1, pc_r};
            end
            pc_nxt = pc_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          cursor_nxt = '0;
          drop_nxt   = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      // breadth-first build: root children first, then one queued node at a time
      ST_B_ROOT: begin
        lk_node_nxt = '0;  lk_sym_nxt = sym_r;  lk_chk_nxt = 1'b1;
        ret_nxt = ST_B_ROOT_R;  state_nxt = ST_LK_ADDR;
      end
      ST_B_ROOT_R: begin
        if (lk_res_r != '0) begin
          fl_we = 1'b1;  fl_waddr = lk_res_r;  fl_wdata = '0;
          q_we  = 1'b1;  q_waddr = tail_r[NODE_W-1:0];  q_wdata = lk_res_r;
          tail_nxt = tail_r + 1'b1;
        end
        sym_nxt = sym_r + 1'b1;
        state_nxt = (sym_r == SYM_LAST) ? ST_B_POP : ST_B_ROOT;
      end
      ST_B_POP: begin
        if (head_r == tail_r) begin
          state_nxt = ST_IDLE;
        end else begin
          q_raddr   = head_r[NODE_W-1:0];
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_B_Q;
        end
      end
      ST_B_Q: begin
        now_nxt   = q_rdata;
        fl_raddr  = q_rdata;
        state_nxt = ST_B_F;
      end
      ST_B_F: begin
        f_nxt     = fl_rdata;
        sym_nxt   = '0;
        state_nxt = ST_B_C;
      end
      ST_B_C: begin
        lk_node_nxt = now_r;  lk_sym_nxt = sym_r;  lk_chk_nxt = 1'b1;
        ret_nxt = ST_B_V;  state_nxt = ST_LK_ADDR;
      end
      ST_B_V: begin
        c_nxt = lk_res_r;
        lk_node_nxt = f_r;  lk_sym_nxt = sym_r;  lk_chk_nxt = (f_r == '0);
        ret_nxt = ST_B_W;  state_nxt = ST_LK_ADDR;
      end
      ST_B_W: begin
        // every entry of a processed node is rewritten, so later reads are raw
        nn_we = 1'b1;  nn_waddr = {now_r, sym_r};
        if (c_r == '0) begin
          nn_wdata = lk_res_r;
        end else begin
          nn_wdata = c_r;
          fl_we = 1'b1;  fl_waddr = c_r;  fl_wdata = lk_res_r;
          q_we  = 1'b1;  q_waddr = tail_r[NODE_W-1:0];  q_wdata = c_r;
          tail_nxt = tail_r + 1'b1;
        end
        sym_nxt = sym_r + 1'b1;
        state_nxt = (sym_r == SYM_LAST) ? ST_B_POP : ST_B_C;
      end

      // text walk: step, then follow the failure chain marking terminals
      ST_T_MOVE: begin
        cursor_nxt = lk_res_r;
        t_nxt      = lk_res_r;
        state_nxt  = ST_T_CHK;
      end
      ST_T_CHK: begin
        if (t_r == '0) begin
          state_nxt = ST_T_END;
        end else begin
          tm_raddr  = t_r;
          fl_raddr  = t_r;
          state_nxt = ST_T_TERM;
        end
      end
      ST_T_TERM: begin
        t_nxt = fl_rdata;
        if (tm_rdata[TERM_W-1]) begin
          sn_raddr  = tm_rdata[SEEN_AW-1:0];
          id_nxt    = tm_rdata[SEEN_AW-1:0];
          state_nxt = ST_T_SEEN;
        end else begin
          state_nxt = ST_T_CHK;
        end
      end
      ST_T_SEEN: begin
        if (!sn_rdata[0]) begin
          sn_we = 1'b1;  sn_waddr = id_r;  sn_wdata = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = ST_T_CHK;
      end
      ST_T_END: begin
        if (last_r) begin
          cursor_nxt = '0;
          state_nxt  = ST_T_OUT;
        end else begin
          state_nxt  = ST_IDLE;
        end
      end
      ST_T_OUT: begin
        if (res_ready) begin
          cnt_nxt   = '0;
          sw_nxt    = '0;
          state_nxt = ST_SWEEP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/multi_pattern_byte_matcher_top.sv @@
// top level: stream ports, result register and the automaton engine
// clear and the last text word are followed by a sweep of the seen-pattern set
// a text word after a build also walks every node on its failure chain
// a build does two transition lookups per symbol of every queued node
// one word at a time; the result register lets the next word in while it waits
// reset acts as a clear: root-only trie, then the seen sweep
module multi_pattern_byte_matcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] op, [9:2] byte_value, [15:10] zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [9:0] match_count, [10] overflow, [15:11] zero
);
  import mbm_pkg::*;

  req_t req;
  res_t res;
  logic eng_ready;
  logic res_ready;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_ovf_r;

  // input word straight into the engine when it is idle
  assign req.valid      = in_tvalid;
  assign req.op         = op_t'(in_tdata[1:0]);
  assign req.byte_value = in_tdata[9:2];
  assign req.last       = in_tlast;
  assign in_tready      = eng_ready;

  // result register frees the engine as soon as the count is taken
  assign res_ready = !out_valid_r || out_tready;

  mbm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .ready     (eng_ready),
    .res       (res),
    .res_ready (res_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
    if (res_ready && res.valid) begin
      out_cnt_r <= res.match_count;
      out_ovf_r <= res.overflow;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_ovf_r, out_cnt_r};

endmodule

@@ rtl/mbm_checker.sv @@
// port-level checker for the matcher top level, with its bind
module mbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn while stalled");

  // count never exceeds the pattern limit
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9:0] <= 10'd512))
    else $error("match count out of range");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word after reset");

  // reset starts the seen sweep, so no word is taken just after it
  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during reset sweep");

endmodule

bind multi_pattern_byte_matcher_top mbm_checker u_mbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/tb_multi_pattern_byte_matcher_top.sv @@
// self-checking testbench of the multi-pattern byte matcher with an automaton predictor
module tb_multi_pattern_byte_matcher_top;
  import mbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // scoreboard: keeps its own automaton and the queue of expected match reports
  class match_scoreboard;
    bit [NODE_W-1:0] trans [0:MAX_NODES*ALPHABET-1];
    bit [NODE_W-1:0] fail  [0:MAX_NODES-1];
    bit [PAT_W-1:0]  term_num [0:MAX_NODES-1];
    bit              term_ok  [0:MAX_NODES-1];
    bit              seen     [0:MAX_PATTERNS-1];
    bit [NODE_W-1:0] bfs      [0:MAX_NODES-1];
    int unsigned     nodes, patterns, cur;
    bit              ovf, built, dropping;
    bit [CNT_W-1:0]  exp_count [$];
    bit              exp_ovf   [$];
    int              mismatches;

    function new();
      mismatches = 0;
      clear_trie();
    endfunction

    function void open_node(int unsigned nd);
      for (int s = 0; s < ALPHABET; s++) trans[nd*ALPHABET+s] = '0;
      term_ok[nd] = 0;
      term_num[nd] = '0;
      fail[nd] = '0;
    endfunction

    function void clear_trie();
      nodes = 1;
      open_node(0);
      patterns = 0;
      cur = 0;
      ovf = 0;
      built = 0;
      dropping = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void add_pattern_byte(int unsigned sym, bit fin);
      int unsigned c;
      if (built) return;
      if (!dropping) begin
        c = trans[cur*ALPHABET+sym];
        if (c == 0) begin
          if (nodes < MAX_NODES) begin
            c = nodes++;
            open_node(c);
            trans[cur*ALPHABET+sym] = NODE_W'(c);
            cur = c;
          end else begin
            ovf = 1;
            dropping = 1;
          end
        end else begin
          cur = c;
        end
      end
      if (fin) begin
        if (patterns < MAX_PATTERNS) begin
          if (!dropping) begin
            term_num[cur] = PAT_W'(patterns);
            term_ok[cur] = 1;
          end
          patterns++;
        end else begin
          ovf = 1;
        end
        cur = 0;
        dropping = 0;
      end
    endfunction

    function void build_links();
      int unsigned head, tail, c, via, nd, f;
      head = 0;
      tail = 0;
      cur = 0;
      dropping = 0;
      if (built) return;
      built = 1;
      for (int s = 0; s < ALPHABET; s++) begin
        c = trans[s];
        if (c != 0 && c < nodes && tail < MAX_NODES) begin
          fail[c] = '0;
          bfs[tail++] = NODE_W'(c);
        end
      end
      while (head < tail) begin
        nd = bfs[head++];
        f = fail[nd];
        for (int s = 0; s < ALPHABET; s++) begin
          c = trans[nd*ALPHABET+s];
          via = trans[f*ALPHABET+s];
          if (c == 0) trans[nd*ALPHABET+s] = NODE_W'(via);
          else if (c < nodes && tail < MAX_NODES) begin
            fail[c] = NODE_W'(via);
            bfs[tail++] = NODE_W'(c);
          end
        end
      end
    endfunction

    function void walk_text(int unsigned sym);
      int unsigned t;
      if (!built) return;
      cur = trans[cur*ALPHABET+sym];
      if (cur >= nodes) cur = 0;
      t = cur;
      for (int g = 0; t != 0 && g < MAX_NODES; g++) begin
        if (term_ok[t] && term_num[t] < MAX_PATTERNS) seen[term_num[t]] = 1;
        t = fail[t];
        if (t >= nodes) t = 0;
      end
    endfunction

    // an accepted input word: advance the automaton, queue a report on end of text
    function void note_word(op_t op, bit [7:0] b, bit fin);
      int unsigned cnt;
      case (op)
        OP_CLEAR: clear_trie();
        OP_PAT:   add_pattern_byte(b % ALPHABET, fin);
        OP_BUILD: build_links();
        default: begin
          walk_text(b % ALPHABET);
          if (fin) begin
            cnt = 0;
            for (int i = 0; i < patterns && i < MAX_PATTERNS; i++) if (seen[i]) cnt++;
            foreach (seen[i]) seen[i] = 0;
            cur = 0;
            exp_count.push_back(cnt[CNT_W-1:0]);
            exp_ovf.push_back(ovf);
          end
        end
      endcase
    endfunction

    function void check_report(bit [CNT_W-1:0] cnt, bit of);
      bit [CNT_W-1:0] ec;
      bit eo;
      if (exp_count.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report: count %0d overflow %0b", cnt, of);
        return;
      end
      ec = exp_count.pop_front();
      eo = exp_ovf.pop_front();
      if (ec !== cnt || eo !== of) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: count exp %0d got %0d, overflow exp %0b got %0b",
                   ec, cnt, eo, of);
      end
    endfunction

    function int pending();
      return exp_count.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  match_scoreboard sb;
  int burst_left;
  int rx_mode;
  int rx_left;

  multi_pattern_byte_matcher_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: segments of free flow, random stalls and long stalls
  initial begin
    out_tready <= 0;
    rx_mode = 0;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata[9:0], out_tdata[10]);
  end

  // send one word; the sender runs in bursts with idle gaps in between
  task automatic send_word(op_t op, logic [7:0] b, logic fin);
    if (burst_left == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 15);
    end
    in_tvalid <= 1;
    in_tdata  <= {6'b0, b, op};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_word(op, b, fin);
    burst_left--;
  endtask

  // hold the sender until every report is back, then let the seen sweep finish
  task automatic drain();
    in_tvalid <= 0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // one random session: clear, short patterns over a small symbol set, build, texts
  task automatic run_session();
    logic [7:0] syms [4];
    int npat, len, ntext;
    logic [7:0] b;
    foreach (syms[i]) syms[i] = 8'($urandom_range(0, 255));
    send_word(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) send_word(OP_TEXT, syms[0], 1);
    npat = $urandom_range(1, 6);
    for (int p = 0; p < npat; p++) begin
      len = $urandom_range(1, 3);
      for (int k = 0; k < len; k++) begin
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : syms[$urandom_range(0, 3)];
        send_word(OP_PAT, b, k == len - 1);
      end
    end
    // an unfinished pattern before the build is discarded
    if ($urandom_range(0, 2) == 0) send_word(OP_PAT, syms[1], 0);
    send_word(OP_BUILD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) send_word(OP_BUILD, 8'($urandom_range(0, 255)), 1);
    if ($urandom_range(0, 3) == 0) send_word(OP_PAT, syms[2], 1'($urandom_range(0, 1)));
    ntext = $urandom_range(6, 12);
    for (int t = 0; t < ntext; t++) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : syms[$urandom_range(0, 3)];
        send_word(OP_TEXT, b, k == len - 1);
      end
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    rst_n     <= 0;
    in_tvalid <= 0;
    in_tdata  <= '0;
    in_tlast  <= 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: text before any build still reports
    send_word(OP_TEXT, 8'h00, 1);
    // classic pattern set he, she, his, hers
    send_word(OP_PAT, "h", 0); send_word(OP_PAT, "e", 1);
    send_word(OP_PAT, "s", 0); send_word(OP_PAT, "h", 0); send_word(OP_PAT, "e", 1);
    send_word(OP_PAT, "h", 0); send_word(OP_PAT, "i", 0); send_word(OP_PAT, "s", 1);
    send_word(OP_PAT, "h", 0); send_word(OP_PAT, "e", 0); send_word(OP_PAT, "r", 0);
    send_word(OP_PAT, "s", 1);
    // extreme symbols, a repeated pattern, then build in the middle of a pattern
    send_word(OP_PAT, 8'hff, 1); send_word(OP_PAT, 8'h00, 1); send_word(OP_PAT, "h", 0);
    send_word(OP_PAT, "e", 1);
    send_word(OP_PAT, 8'hff, 0);
    send_word(OP_BUILD, 8'hff, 1);
    send_word(OP_BUILD, 8'h00, 0);
    send_word(OP_PAT, "x", 1);   // ignored once built
    send_word(OP_TEXT, "u", 0); send_word(OP_TEXT, "s", 0); send_word(OP_TEXT, "h", 0);
    send_word(OP_TEXT, "e", 0); send_word(OP_TEXT, "r", 0); send_word(OP_TEXT, "s", 1);
    send_word(OP_TEXT, 8'hff, 0); send_word(OP_TEXT, 8'h00, 1);
    drain();

    // pattern numbers run out: 513 copies of one byte
    send_word(OP_CLEAR, 8'h00, 0);
    for (int i = 0; i <= MAX_PATTERNS; i++) send_word(OP_PAT, 8'h41, 1);
    send_word(OP_BUILD, 8'h00, 0);
    send_word(OP_TEXT, 8'h41, 1);
    drain();

    for (int n = 0; n < 18; n++) run_session();

    in_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
